>>> src/rht_pkg.sv
// Shared constants, command codes and helpers for the range histogram tally.
// No dependencies; used by rht_div and range_histogram_tally.
`default_nettype none

package rht_pkg;

  localparam int MAX_BINS  = 1024;
  localparam int BIN_AW    = $clog2(MAX_BINS);
  localparam int COUNT_W   = 32;
  localparam int NB_W      = 11;
  localparam int DVD_W     = 33;
  localparam int DSR_W     = 31;
  localparam int DIV_STEPS = DVD_W;
  localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

  // Q16.16 one, stands in for a zero clump size
  localparam logic [DSR_W-1:0] ONE_Q = DSR_W'(65536);

  localparam logic [1:0] CMD_TALLY = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [1:0] REG_HIST_MIN = 2'd0;
  localparam logic [1:0] REG_HIST_MAX = 2'd1;
  localparam logic [1:0] REG_BIN_CNT  = 2'd2;
  localparam logic [1:0] REG_CLUMP    = 2'd3;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (&v) ? v : v + COUNT_W'(1);
  endfunction

endpackage

`default_nettype wire

>>> src/range_histogram_tally.sv
// Top level of the range histogram tally: control FSM, bin store and counter.
// Depends on rht_pkg and rht_div (two instances, one per span edge).
//
//   channel  dir  handshake            payload
//   in_      in   in_tvalid/in_tready  tuser: cmd; tdata: low, high, read_index
//   out_     out  out_tvalid/out_tready tuser: range_error; tdata: bin, total
//   cfg_     in   cfg_we               cfg_index, cfg_wdata
//
// Work: a tally runs the 33-step dividers (both edges divided side by side),
// then a read-modify-write sweep of the bin memory over the bins covered,
// reading one row while writing back another. A clear zeroes one memory row
// per cycle.
// Reset: synchronous, active low; it is followed by a clearing pass over all
// 1024 rows of the bin memory, during which in_tready stays low.
// Stalls: one item is worked at a time; the next is taken while the previous
// result still waits in the output register, and the FSM holds its response
// until that register is free.
`default_nettype none

module range_histogram_tally (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [79:0] in_tdata,   // low_value[31:0], high_value[63:32],
                                       // read_index[73:64], zero pad above
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata,  // bin_value[31:0], sample_total[63:32]
  output logic [0:0]       out_tuser,  // range_error[0]
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [30:0] cfg_wdata
);

  typedef enum logic [3:0] {
    ST_INIT, ST_IDLE, ST_DIVGO, ST_DIV, ST_CHECK, ST_SWEEP, ST_DRAIN,
    ST_RD, ST_RDW, ST_CLR, ST_RESP
  } state_t;

  // configuration registers
  logic signed [15:0]         hist_min_r;
  logic signed [15:0]         hist_max_r;
  logic [rht_pkg::NB_W-1:0]   bin_count_r;
  logic [rht_pkg::DSR_W-1:0]  clump_r;

  // item context
  state_t                     state_r;
  logic [rht_pkg::BIN_AW-1:0] idx_r;
  logic signed [33:0]         lo_diff_r;
  logic signed [33:0]         hi_diff_r;
  logic                       lo_le_r;
  logic                       hi_ge_r;
  logic [rht_pkg::NB_W-1:0]   nb_r;
  logic [rht_pkg::BIN_AW-1:0] sw_addr_r;
  logic [rht_pkg::BIN_AW-1:0] last_r;
  logic [rht_pkg::COUNT_W-1:0] count_r;
  logic [rht_pkg::COUNT_W-1:0] resp_bin_r;
  logic                       resp_err_r;

  // read-modify-write stage
  logic                       rmw_v_r;
  logic [rht_pkg::BIN_AW-1:0] rmw_addr_r;
  logic [rht_pkg::COUNT_W-1:0] rd_data_r;

  // output register
  logic                       out_valid_r;
  logic [rht_pkg::COUNT_W-1:0] out_bin_r;
  logic [rht_pkg::COUNT_W-1:0] out_total_r;
  logic                       out_err_r;

  // bin store
  logic [rht_pkg::COUNT_W-1:0] bin_mem [rht_pkg::MAX_BINS];
  logic                        mem_we;
  logic                        mem_re;
  logic [rht_pkg::BIN_AW-1:0]  mem_waddr;
  logic [rht_pkg::BIN_AW-1:0]  mem_raddr;
  logic [rht_pkg::COUNT_W-1:0] mem_wdata;

  // edge arithmetic on the incoming item
  logic signed [33:0]         minq;
  logic signed [16:0]         maxe;
  logic signed [33:0]         maxq;
  logic signed [33:0]         lo_ext;
  logic signed [33:0]         hi_ext;
  logic [rht_pkg::NB_W-1:0]   nb_sat;

  // dividers
  logic                       div_start;
  logic [rht_pkg::DVD_W-1:0]  dvd_lo;
  logic [rht_pkg::DVD_W-1:0]  dvd_hi;
  logic signed [33:0]         hi_neg;
  logic [rht_pkg::DSR_W-1:0]  divisor;
  logic                       done_lo;
  logic                       done_hi;
  logic [rht_pkg::DVD_W-1:0]  q_lo;
  logic [rht_pkg::DVD_W-1:0]  q_hi;

  // span decision
  logic [rht_pkg::DVD_W-1:0]  first_q;
  logic [rht_pkg::DVD_W-1:0]  last_mag;
  logic                       last_neg;
  logic                       span_err;
  logic                       span_empty;

  logic                       in_fire;
  logic                       out_free;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // Q16.16 edges; an empty interval gets an upper edge of min+1
  assign minq   = {{2{hist_min_r[15]}}, hist_min_r, 16'h0000};
  assign maxe   = (hist_max_r <= hist_min_r) ? ({hist_min_r[15], hist_min_r} + 17'sd1)
                                             : {hist_max_r[15], hist_max_r};
  assign maxq   = {maxe[16], maxe, 16'h0000};
  assign lo_ext = {{2{in_tdata[31]}}, in_tdata[31:0]};
  assign hi_ext = {{2{in_tdata[63]}}, in_tdata[63:32]};
  assign nb_sat = (bin_count_r < rht_pkg::NB_W'(2)) ? rht_pkg::NB_W'(2) :
                  (bin_count_r > rht_pkg::NB_W'(rht_pkg::MAX_BINS))
                    ? rht_pkg::NB_W'(rht_pkg::MAX_BINS) : bin_count_r;

  // truncation toward zero: divide the magnitude, sign handled afterwards
  assign hi_neg    = -hi_diff_r;
  assign dvd_lo    = lo_diff_r[rht_pkg::DVD_W-1:0];
  assign dvd_hi    = hi_diff_r[33] ? hi_neg[rht_pkg::DVD_W-1:0]
                                   : hi_diff_r[rht_pkg::DVD_W-1:0];
  assign divisor   = (clump_r == '0) ? rht_pkg::ONE_Q : clump_r;
  assign div_start = (state_r == ST_DIVGO);

  rht_div u_div_lo (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_lo),
    .divisor  (divisor),
    .done     (done_lo),
    .quotient (q_lo)
  );

  rht_div u_div_hi (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dvd_hi),
    .divisor  (divisor),
    .done     (done_hi),
    .quotient (q_hi)
  );

  // a negative high offset below one clump still lands in bin zero
  assign first_q    = lo_le_r ? '0 : q_lo;
  assign last_neg   = !hi_ge_r && hi_diff_r[33] && (q_hi != '0);
  assign last_mag   = hi_ge_r      ? rht_pkg::DVD_W'(nb_r - rht_pkg::NB_W'(1)) :
                      hi_diff_r[33] ? '0 : q_hi;
  assign span_err   = !last_neg && (last_mag >= rht_pkg::DVD_W'(nb_r));
  assign span_empty = last_neg || (first_q > last_mag);

  // memory port steering: the init and clear passes zero rows, otherwise the RMW write-back
  always_comb begin
    mem_re    = (state_r == ST_SWEEP) || (state_r == ST_RD);
    mem_raddr = (state_r == ST_RD) ? idx_r : sw_addr_r;
    if ((state_r == ST_INIT) || (state_r == ST_CLR)) begin
      mem_we    = 1'b1;
      mem_waddr = sw_addr_r;
      mem_wdata = '0;
    end else begin
      mem_we    = rmw_v_r;
      mem_waddr = rmw_addr_r;
      mem_wdata = rht_pkg::sat_inc(rd_data_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bin_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= bin_mem[mem_raddr];
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_min_r  <= 16'sd0;
      hist_max_r  <= 16'sd1;
      bin_count_r <= rht_pkg::NB_W'(2);
      clump_r     <= rht_pkg::ONE_Q;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rht_pkg::REG_HIST_MIN: hist_min_r  <= cfg_wdata[15:0];
        rht_pkg::REG_HIST_MAX: hist_max_r  <= cfg_wdata[15:0];
        rht_pkg::REG_BIN_CNT:  bin_count_r <= cfg_wdata[rht_pkg::NB_W-1:0];
        rht_pkg::REG_CLUMP:    clump_r     <= cfg_wdata[rht_pkg::DSR_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers of the item, no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      idx_r     <= in_tdata[64 +: rht_pkg::BIN_AW];
      lo_diff_r <= lo_ext - minq;
      hi_diff_r <= hi_ext - minq;
      lo_le_r   <= lo_ext <= minq;
      hi_ge_r   <= hi_ext >= maxq;
      nb_r      <= nb_sat;
    end
    rmw_addr_r <= sw_addr_r;
    if (state_r == ST_CHECK) begin
      last_r <= last_mag[rht_pkg::BIN_AW-1:0];
    end
  end

  // control FSM and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sw_addr_r   <= '0;
      count_r     <= '0;
      rmw_v_r     <= 1'b0;
      resp_bin_r  <= '0;
      resp_err_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_bin_r   <= '0;
      out_total_r <= '0;
      out_err_r   <= 1'b0;
    end else begin
      rmw_v_r <= (state_r == ST_SWEEP);
      // the response state reloads the output register itself
      if (out_tready && (state_r != ST_RESP)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_INIT: begin
          sw_addr_r <= sw_addr_r + rht_pkg::BIN_AW'(1);
          if (sw_addr_r == rht_pkg::BIN_AW'(rht_pkg::MAX_BINS - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            resp_bin_r <= '0;
            resp_err_r <= 1'b0;
            case (in_tuser)
              rht_pkg::CMD_TALLY: state_r <= ST_DIVGO;
              rht_pkg::CMD_READ:  state_r <= ST_RD;
              rht_pkg::CMD_CLEAR: begin
                sw_addr_r <= '0;
                count_r   <= '0;
                state_r   <= ST_CLR;
              end
              default:            state_r <= ST_RESP;
            endcase
          end
        end
        ST_DIVGO: state_r <= ST_DIV;
        ST_DIV: begin
          if (done_lo && done_hi) begin
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (span_err) begin
            resp_err_r <= 1'b1;
            state_r    <= ST_RESP;
          end else begin
            count_r <= rht_pkg::sat_inc(count_r);
            if (span_empty) begin
              state_r <= ST_RESP;
            end else begin
              sw_addr_r <= first_q[rht_pkg::BIN_AW-1:0];
              state_r   <= ST_SWEEP;
            end
          end
        end
        ST_SWEEP: begin
          // one read per cycle; the write-back of each row follows in the next cycle
          sw_addr_r <= sw_addr_r + rht_pkg::BIN_AW'(1);
          if (sw_addr_r == last_r) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: state_r <= ST_RESP;
        ST_RD:    state_r <= ST_RDW;
        ST_RDW: begin
          resp_bin_r <= rd_data_r;
          state_r    <= ST_RESP;
        end
        ST_CLR: begin
          sw_addr_r <= sw_addr_r + rht_pkg::BIN_AW'(1);
          if (sw_addr_r == rht_pkg::BIN_AW'(rht_pkg::MAX_BINS - 1)) begin
            state_r <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_bin_r   <= resp_bin_r;
            out_total_r <= count_r;
            out_err_r   <= resp_err_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_total_r, out_bin_r};
  assign out_tuser  = out_err_r;

  // no write-back may still be in flight when a new item can enter
  a_idle_no_rmw: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !rmw_v_r)
    else $error("bin write-back pending while idle");

  // the sweep never reads the row being written back
  a_rmw_no_alias: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("read and write to the same bin in one cycle");

  // both dividers run in lockstep
  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    done_lo == done_hi)
    else $error("span dividers out of step");

  // an error result never carries a bin count
  a_err_zero_bin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata[31:0] == 32'h0))
    else $error("range error with non-zero bin value");

endmodule

`default_nettype wire

>>> src/rht_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rht_pkg for operand widths and step count.
`default_nettype none

module rht_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rht_pkg::DVD_W-1:0] dividend,
  input  wire logic [rht_pkg::DSR_W-1:0] divisor,
  output logic                           done,
  output logic [rht_pkg::DVD_W-1:0]      quotient
);

  logic                       busy_r;
  logic                       done_r;
  logic [rht_pkg::DIV_CW-1:0] cnt_r;
  logic [rht_pkg::DSR_W-1:0]  rem_r;
  logic [rht_pkg::DSR_W-1:0]  dsr_r;
  logic [rht_pkg::DVD_W-1:0]  q_r;
  logic [rht_pkg::DSR_W:0]    trial;
  logic                       fits;

  // shift in next dividend bit, subtract if it fits
  assign trial = {rem_r, q_r[rht_pkg::DVD_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= rht_pkg::DIV_CW'(rht_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - rht_pkg::DIV_CW'(1);
        if (cnt_r == rht_pkg::DIV_CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dsr_r <= divisor;
      q_r   <= dividend;
    end else if (busy_r) begin
      rem_r <= fits ? rht_pkg::DSR_W'(trial - {1'b0, dsr_r}) : trial[rht_pkg::DSR_W-1:0];
      q_r   <= {q_r[rht_pkg::DVD_W-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

`default_nettype wire

>>> test/tb_range_histogram_tally.sv
// Self-checking testbench for range_histogram_tally: directed and random stream traffic,
// scored against an in-bench histogram predictor held in a small scoreboard class.
// Depends on rht_pkg for command and register codes and on the RTL top level.
module tb_range_histogram_tally;
  timeunit 1ns;
  timeprecision 1ps;

  // One result transaction as the block should return it
  typedef struct packed {
    logic [31:0] bin_value;
    logic [31:0] sample_total;
    logic        range_error;
  } tally_result_t;

  // Scoreboard: a copy of the histogram state, advanced on every accepted
  // input transaction, and the queue of results still owed by the block.
  class histogram_board;
    logic signed [15:0] lo_edge;
    logic signed [15:0] hi_edge;
    logic [10:0]        bins_cfg;
    logic [30:0]        clump_cfg;
    logic [31:0]        bin_counts [rht_pkg::MAX_BINS];
    logic [31:0]        tally_count;
    tally_result_t      owed_results [$];
    int                 fails;

    function new();
      lo_edge     = 16'sd0;
      hi_edge     = 16'sd1;
      bins_cfg    = 11'd2;
      clump_cfg   = 31'd65536;
      tally_count = '0;
      fails       = 0;
      foreach (bin_counts[i]) bin_counts[i] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [30:0] data);
      case (idx)
        rht_pkg::REG_HIST_MIN: lo_edge   = data[15:0];
        rht_pkg::REG_HIST_MAX: hi_edge   = data[15:0];
        rht_pkg::REG_BIN_CNT:  bins_cfg  = data[10:0];
        rht_pkg::REG_CLUMP:    clump_cfg = data;
        default: ;
      endcase
    endfunction

    // Span of bins touched by one tally, then the saturating updates
    function tally_result_t predict_tally(logic signed [31:0] low, logic signed [31:0] high);
      longint        minq;
      longint        maxq;
      longint        nb;
      longint        clump;
      longint        lo;
      longint        hi;
      longint        first;
      longint        last;
      longint        i;
      tally_result_t r;
      minq  = longint'(lo_edge) * 65536;
      // an empty interval is widened to one unit above the lower edge
      maxq  = (hi_edge <= lo_edge) ? (longint'(lo_edge) + 1) * 65536
                                   : longint'(hi_edge) * 65536;
      nb    = longint'(bins_cfg);
      if (nb < 2) nb = 2;
      if (nb > rht_pkg::MAX_BINS) nb = rht_pkg::MAX_BINS;
      clump = (clump_cfg == '0) ? 65536 : longint'(clump_cfg);
      lo    = low;
      hi    = high;
      first = (lo <= minq) ? 0 : (lo - minq) / clump;
      last  = (hi >= maxq) ? nb - 1 : (hi - minq) / clump;
      r.bin_value = '0;
      if (first < 0 || last >= nb) begin
        // span runs off the store: flag it, touch nothing
        r.sample_total = tally_count;
        r.range_error  = 1'b1;
        return r;
      end
      for (i = first; i <= last; i++)
        if (bin_counts[i] != '1) bin_counts[i] = bin_counts[i] + 32'd1;
      if (tally_count != '1) tally_count = tally_count + 32'd1;
      r.sample_total = tally_count;
      r.range_error  = 1'b0;
      return r;
    endfunction

    function void note_item(logic [1:0] cmd, logic signed [31:0] low,
                            logic signed [31:0] high, logic [9:0] idx);
      tally_result_t r;
      r.bin_value    = '0;
      r.sample_total = tally_count;
      r.range_error  = 1'b0;
      case (cmd)
        rht_pkg::CMD_TALLY: r = predict_tally(low, high);
        rht_pkg::CMD_READ:  r.bin_value = bin_counts[idx];
        rht_pkg::CMD_CLEAR: begin
          foreach (bin_counts[i]) bin_counts[i] = '0;
          tally_count    = '0;
          r.sample_total = '0;
        end
        default: ;
      endcase
      owed_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] bin_value, logic [31:0] sample_total,
                               logic range_error);
      tally_result_t exp_r;
      if (owed_results.size() == 0) begin
        $error("unexpected result: bin_value %0d, sample_total %0d, range_error %0b",
               bin_value, sample_total, range_error);
        fails++;
        return;
      end
      exp_r = owed_results.pop_front();
      if (bin_value !== exp_r.bin_value) begin
        $error("bin_value: expected %0d, actual %0d", exp_r.bin_value, bin_value);
        fails++;
      end
      if (sample_total !== exp_r.sample_total) begin
        $error("sample_total: expected %0d, actual %0d", exp_r.sample_total, sample_total);
        fails++;
      end
      if (range_error !== exp_r.range_error) begin
        $error("range_error: expected %0b, actual %0b", exp_r.range_error, range_error);
        fails++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Signals, all inputs known from time zero
  // ---------------------------------------------------------------------------
  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [79:0] in_tdata  = '0;  // low_value[31:0], high_value[63:32], read_index[73:64]
  logic [1:0]  in_tuser  = '0;  // cmd[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // bin_value[31:0], sample_total[63:32]
  logic [0:0]  out_tuser;       // range_error[0]
  logic        cfg_we    = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_wdata = '0;

  histogram_board board;

  // Idle rates in percent, changed between phases
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // Current interval as the stimulus sees it, to aim tallies at the bins
  longint cur_minq;
  longint cur_maxq;
  longint cur_clump;
  int     cur_nb;

  range_histogram_tally uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop: sized well above the slowest legal run (every tally sweeping
  // all 1024 bins, clears, the post-reset clearing pass and heavy stalls).
  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic bit roll(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: tready toggles at the falling edge, transactions are scored
  // at the rising edge on the values held just before it.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    out_tready <= !roll(recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      board.check_result(out_tdata[31:0], out_tdata[63:32], out_tuser[0]);
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one transaction, with random idle cycles in front of it; the
  // prediction is taken at the edge that accepts it.
  task automatic push_item(input logic [1:0] cmd, input logic signed [31:0] lo,
                           input logic signed [31:0] hi, input logic [9:0] idx);
    @(negedge clk);
    while (roll(send_idle_pct)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'd0, idx, hi, lo};
    do @(posedge clk); while (!in_tready);
    board.note_item(cmd, lo, hi, idx);
  endtask

  // Stop sending and hold off until every owed result is back, then give the
  // block a little longer to settle before any register write.
  task automatic drain;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Write all four registers back to back; unused upper data bits carry junk
  // to show they are ignored. Only called with the block idle.
  task automatic load_config(input logic signed [15:0] lo_e, input logic signed [15:0] hi_e,
                             input logic [10:0] nb, input logic [30:0] cl);
    logic [30:0] wdata [4];
    logic [1:0]  regs  [4];
    longint      hi_eff;
    wdata[0] = {15'($urandom), lo_e};
    wdata[1] = {15'($urandom), hi_e};
    wdata[2] = {20'($urandom), nb};
    wdata[3] = cl;
    regs[0]  = rht_pkg::REG_HIST_MIN;
    regs[1]  = rht_pkg::REG_HIST_MAX;
    regs[2]  = rht_pkg::REG_BIN_CNT;
    regs[3]  = rht_pkg::REG_CLUMP;
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_wdata <= wdata[i];
      @(posedge clk);
      board.write_reg(regs[i], wdata[i]);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    hi_eff    = (hi_e <= lo_e) ? longint'(lo_e) + 1 : longint'(hi_e);
    cur_minq  = longint'(lo_e) * 65536;
    cur_maxq  = hi_eff * 65536;
    cur_nb    = (nb < 2) ? 2 : (nb > rht_pkg::MAX_BINS) ? rht_pkg::MAX_BINS : int'(nb);
    cur_clump = (cl == '0) ? 65536 : longint'(cl);
  endtask

  // Configuration for one random phase: the widest interval with the most
  // bins, the widest clump, then random small histograms with the odd
  // degenerate setting thrown in.
  task automatic random_config(input int ph);
    logic signed [15:0] lo_e;
    logic signed [15:0] hi_e;
    logic [10:0]        nb;
    logic [30:0]        cl;
    longint             width;
    longint             nb_eff;
    longint             ideal;
    case (ph)
      0: begin
        lo_e = -16'sd32768;
        hi_e = 16'sd32767;
        nb   = 11'd1024;
      end
      1: begin
        lo_e = -16'sd32768;
        hi_e = 16'sd32767;
        nb   = 11'($urandom_range(2, 8));
      end
      default: begin
        lo_e = 16'($urandom_range(0, 512) - 256);
        if ($urandom_range(0, 7) == 0)
          hi_e = lo_e - 16'($urandom_range(0, 5));
        else
          hi_e = lo_e + 16'($urandom_range(1, 256));
        case ($urandom_range(0, 9))
          0:       nb = 11'($urandom_range(0, 1));
          1:       nb = 11'd2;
          2:       nb = 11'($urandom_range(1025, 2047));
          default: nb = 11'($urandom_range(3, 48));
        endcase
      end
    endcase
    width  = (hi_e <= lo_e) ? 1 : longint'(hi_e) - longint'(lo_e);
    nb_eff = (nb < 2) ? 2 : (nb > rht_pkg::MAX_BINS) ? rht_pkg::MAX_BINS : longint'(nb);
    ideal  = (width * 65536) / nb_eff + 1;
    if (ph == 1)
      cl = 31'h7fffffff;
    else if (ph == 0)
      cl = 31'(ideal);
    else
      case ($urandom_range(0, 7))
        0:       cl = '0;
        1:       cl = 31'($urandom);
        2:       cl = 31'(ideal / 2 + 1);   // too narrow: spans run off the store
        default: cl = 31'(ideal);
      endcase
    load_config(lo_e, hi_e, nb, cl);
  endtask

  // Mostly tallies aimed around the interval, reads of bins in and just past
  // use, some no-ops and an occasional clear.
  task automatic push_random_item;
    int                 pick;
    logic [1:0]         cmd;
    logic [9:0]         idx;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    longint             span;
    longint             a;
    longint             b;
    longint             w;
    pick = $urandom_range(0, 99);
    cmd  = (pick < 58) ? rht_pkg::CMD_TALLY : (pick < 88) ? rht_pkg::CMD_READ :
           (pick < 97) ? rht_pkg::CMD_NOP : rht_pkg::CMD_CLEAR;
    if ($urandom_range(0, 3) == 0)
      idx = 10'($urandom);
    else
      idx = 10'($urandom_range(0, (cur_nb + 1 > 1023) ? 1023 : cur_nb + 1));
    span = cur_maxq - cur_minq;
    if ($urandom_range(0, 9) == 0) begin
      lo = $urandom;
      hi = $urandom;
    end else begin
      a = cur_minq - span / 8 + longint'({$urandom(), $urandom()} % (span * 5 / 4 + 1));
      case ($urandom_range(0, 5))
        0:       w = -longint'($urandom_range(1, 200000));   // empty span
        1:       w = longint'({$urandom(), $urandom()} % (span + 1));
        default: w = cur_clump * longint'($urandom_range(0, 3))
                     + longint'($urandom_range(0, 65535));
      endcase
      b = a + w;
      // land exactly on the edges now and then
      case ($urandom_range(0, 15))
        0: a = cur_minq;
        1: b = cur_maxq;
        2: b = cur_maxq - 1;
        3: a = cur_minq + 1;
        default: ;
      endcase
      lo = clamp32(a);
      hi = clamp32(b);
    end
    push_item(cmd, lo, hi, idx);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    board = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // the block clears its bin memory after reset; wait for it to open up
    do @(posedge clk); while (!in_tready);

    send_idle_pct = 9;
    recv_idle_pct = 76;

    // Directed, part one: eight unit-ish bins over [-4, 4)
    load_config(-16'sd4, 16'sd4, 11'd8, 31'd65537);
    // whole store
    push_item(rht_pkg::CMD_TALLY, 32'sh80000000, 32'sh7fffffff, 10'd0);
    // single bin
    push_item(rht_pkg::CMD_TALLY, 32'sd0, 32'sd0, 10'h3ff);
    // low on the lower edge
    push_item(rht_pkg::CMD_TALLY, -4 * 65536, -1, 10'd0);
    // high below low
    push_item(rht_pkg::CMD_TALLY, 3 * 65536, -2 * 65536, 10'd0);
    // last bin negative
    push_item(rht_pkg::CMD_TALLY, 32'sh80000000, -6 * 65536, 10'd0);
    // high on the upper edge
    push_item(rht_pkg::CMD_TALLY, 4 * 65536 - 1, 4 * 65536, 10'd0);
    push_item(rht_pkg::CMD_READ, 32'sh7fffffff, 32'sh80000000, 10'd0);
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'd3);
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'd7);
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'h3ff);
    push_item(rht_pkg::CMD_NOP, 32'sh5a5a5a5a, 32'sha5a5a5a5, 10'h2aa);
    drain();

    // Part two: inverted edges, bin count under the floor, zero clump
    load_config(16'sd10, 16'sd5, 11'd1, 31'd0);
    push_item(rht_pkg::CMD_TALLY, 10 * 65536 + 32768, 10 * 65536 + 60000, 10'd0);
    push_item(rht_pkg::CMD_TALLY, 9 * 65536, 11 * 65536, 10'd0);
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'd0);
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'd1);
    // above bin count, keeps old count
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'd5);
    drain();

    // Part three: widest interval, bin count over the ceiling, tiny clump
    load_config(-16'sd32768, 16'sd32767, 11'd2047, 31'd64);
    // all 1024 bins
    push_item(rht_pkg::CMD_TALLY, 32'sh80000000, 32'sh80000000 + 32'sd65472, 10'd0);
    // off the end
    push_item(rht_pkg::CMD_TALLY, 32'sh80000000, 32'sh80000000 + 32'sd65536, 10'd0);
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'h3ff);
    push_item(rht_pkg::CMD_CLEAR, 32'sd0, 32'sd0, 10'd0);
    push_item(rht_pkg::CMD_READ, 32'sd0, 32'sd0, 10'h3ff);
    // first > last
    push_item(rht_pkg::CMD_TALLY, 32'sh7fffffff, 32'sh7fffffff, 10'd0);
    drain();

    // Random phases: slow receiver, then slow sender, then full rate
    for (int ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 9;
        recv_idle_pct = 76;
      end else if (ph < 6) begin
        send_idle_pct = 76;
        recv_idle_pct = 9;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      random_config(ph);
      for (int n = 0; n < 50; n++) push_random_item();
      drain();
    end

    if (board.fails == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
src/rht_pkg.sv
src/rht_div.sv
src/range_histogram_tally.sv
test/tb_range_histogram_tally.sv
